### src/ahml_pkg.sv
// ----------------------------------------------------------------------------
// ahml_pkg: shared types and constants of the ASCII hex memory loader
// Holds the command, status and phase codes, the character codes the parser
// looks for, and the word payload structs of the request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ahml_pkg;

   // Command carried by each request word.
   typedef enum logic [1:0] {
      CMD_CHAR    = 2'd0,
      CMD_END     = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NOP     = 2'd3
   } command_type;

   // Status reported with each response word.
   typedef enum logic [2:0] {
      ST_RUN   = 3'd0,
      ST_DONE  = 3'd1,
      ST_FMT   = 3'd2,
      ST_BADCH = 3'd3,
      ST_STOP  = 3'd4
   } status_type;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] LETTER_BIAS  = 8'h37;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   // A header token has exactly this many digits, a data token this many.
   localparam logic [2:0] HEADER_DIGITS = 3'd3;
   localparam logic [2:0] DATA_DIGITS   = 3'd2;
   localparam logic [2:0] DIGITS_MAX    = 3'd7;

   typedef struct packed {
      command_type command;
      logic [7:0]  char_code;
   } req_payload_type;

   typedef struct packed {
      logic        write_valid;
      logic [11:0] write_address;
      logic [7:0]  write_data;
      status_type  status;
      logic [11:0] start_address;
      logic [12:0] end_address;
   } rsp_payload_type;

endpackage

### src/ahml_chan_if.sv
// ----------------------------------------------------------------------------
// ahml_chan_if: valid/ready channel
// Carries one payload word per handshake; the source drives valid and the
// payload, the sink drives ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ahml_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/ascii_hex_memory_loader.sv
// ----------------------------------------------------------------------------
// ascii_hex_memory_loader: ASCII hex load-image parser
// Each response word is computed combinationally and registered in the result or skid register.
// Throughput: one word per cycle while the skid register is empty; the parser state update is a single short step.
// A two-word output stage (result register plus skid register) lets a word be
// accepted while an earlier response is still waiting on rsp_if.ready.
// Reset (synchronous, active high) returns the parser to the header phase with
// all counters and addresses at zero and empties the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_hex_memory_loader #(
   parameter int MEM_DEPTH       = 4096,
   parameter int MAX_LINE_TOKENS = 16
) (
   input logic  clock,
   input logic  reset,
   ahml_chan_if.sink   req_if,
   ahml_chan_if.source rsp_if
);
   import ahml_pkg::*;

   localparam logic [12:0] DEPTH_LIMIT = 13'(MEM_DEPTH);
   localparam logic [5:0]  TOKEN_LIMIT = 6'(MAX_LINE_TOKENS);

   // Parser state.
   phase_type   phase_ff,      phase_in;
   logic [2:0]  digit_cnt_ff,  digit_cnt_in;
   logic [11:0] token_ff,      token_in;
   logic [4:0]  line_cnt_ff,   line_cnt_in;
   logic [11:0] load_start_ff, load_start_in;
   logic [12:0] next_addr_ff,  next_addr_in;

   // Output stage: the result register drives the port, the skid register
   // catches one word while the result register is stalled.
   rsp_payload_type out_ff, skid_ff, result;
   logic            out_valid_ff, skid_valid_ff;

   logic            accept;
   logic            drain;
   req_payload_type word;
   logic            is_num, is_letter, is_sep;
   logic [3:0]      nibble;

   assign word   = req_if.payload;
   // The skid register is the only thing that can hold back a new word.
   assign req_if.ready = !skid_valid_ff;
   assign accept = req_if.valid && !skid_valid_ff;
   assign drain  = out_valid_ff && rsp_if.ready;

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

   // Character classes. Lowercase hex letters fall through to invalid.
   assign is_num    = (word.char_code >= CHAR_ZERO) && (word.char_code <= CHAR_NINE);
   assign is_letter = (word.char_code >= CHAR_UPPER_A) && (word.char_code <= CHAR_UPPER_F);
   assign is_sep    = (word.char_code == CHAR_NEWLINE) || (word.char_code == CHAR_SPACE);
   assign nibble    = is_num ? 4'(word.char_code - CHAR_ZERO)
                             : 4'(word.char_code - LETTER_BIAS);

   // One parser step per request word.
   always_comb begin
      logic [5:0] line_next;
      logic       err;
      logic       newline;

      phase_in      = phase_ff;
      digit_cnt_in  = digit_cnt_ff;
      token_in      = token_ff;
      line_cnt_in   = line_cnt_ff;
      load_start_in = load_start_ff;
      next_addr_in  = next_addr_ff;

      result               = '0;
      result.status        = ST_RUN;

      line_next = {1'b0, line_cnt_ff} + 6'd1;
      err       = 1'b0;
      newline   = (word.char_code == CHAR_NEWLINE);

      unique case (word.command)
         CMD_RESTART: begin
            phase_in      = PH_HEADER;
            digit_cnt_in  = '0;
            token_in      = '0;
            line_cnt_in   = '0;
            load_start_in = '0;
            next_addr_in  = '0;
         end
         CMD_NOP: begin
            result.status = (phase_ff == PH_STOP) ? ST_STOP : ST_RUN;
         end
         CMD_CHAR, CMD_END: begin
            priority if (phase_ff == PH_STOP) begin
               result.status = ST_STOP;
            end else if (word.command == CMD_END) begin
               // A partial token is dropped. Ending inside the header is an error.
               digit_cnt_in  = '0;
               token_in      = '0;
               result.status = (phase_ff == PH_DATA) ? ST_DONE : ST_FMT;
               phase_in      = PH_STOP;
            end else if (is_num || is_letter) begin
               token_in = {token_ff[7:0], nibble};
               if (digit_cnt_ff < DIGITS_MAX) begin
                  digit_cnt_in = digit_cnt_ff + 3'd1;
               end
            end else if (is_sep) begin
               if (phase_ff == PH_HEADER) begin
                  if ((digit_cnt_ff == HEADER_DIGITS) && newline) begin
                     load_start_in = token_ff;
                     next_addr_in  = {1'b0, token_ff};
                     line_cnt_in   = '0;
                     phase_in      = PH_DATA;
                  end else begin
                     result.status = ST_FMT;
                     phase_in      = PH_STOP;
                  end
               end else begin
                  if (digit_cnt_ff == DATA_DIGITS) begin
                     if (next_addr_ff >= DEPTH_LIMIT) begin
                        err = 1'b1;
                     end else begin
                        result.write_valid   = 1'b1;
                        result.write_address = next_addr_ff[11:0];
                        result.write_data    = token_ff[7:0];
                        next_addr_in         = next_addr_ff + 13'd1;
                     end
                  end else if (digit_cnt_ff != 3'd0) begin
                     err = 1'b1;
                  end
                  // The token count restarts on each newline; too many tokens
                  // on one line still writes its byte but stops the load.
                  if (!err) begin
                     if (newline) begin
                        line_next = '0;
                     end
                     if (line_next > TOKEN_LIMIT) begin
                        err = 1'b1;
                     end
                  end
                  line_cnt_in = line_next[4:0];
                  if (err) begin
                     result.status = ST_FMT;
                     phase_in      = PH_STOP;
                  end
               end
               digit_cnt_in = '0;
               token_in     = '0;
            end else begin
               result.status = ST_BADCH;
            end
         end
         default: begin
            result.status = ST_RUN;
         end
      endcase

      result.start_address = load_start_in;
      result.end_address   = next_addr_in;
   end

   // Parser state registers advance only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         digit_cnt_ff  <= '0;
         token_ff      <= '0;
         line_cnt_ff   <= '0;
         load_start_ff <= '0;
         next_addr_ff  <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         digit_cnt_ff  <= digit_cnt_in;
         token_ff      <= token_in;
         line_cnt_ff   <= line_cnt_in;
         load_start_ff <= load_start_in;
         next_addr_ff  <= next_addr_in;
      end
   end

   // Output stage control. Words leave in order: the skid word always moves
   // into the result register before any newer word can be accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output stage payload.
   always_ff @(posedge clock) begin
      if (drain || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

endmodule

### src/ahml_checker.sv
// ----------------------------------------------------------------------------
// ahml_checker: port-level checks of the ASCII hex memory loader
// Watches the response channel and checks address bookkeeping and handshake
// behavior over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahml_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ahml_pkg::rsp_payload_type rsp_payload
);
   import ahml_pkg::*;

   // A stalled response word must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A written byte leaves end_address one past its own address.
   a_write_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_valid |->
         rsp_payload.end_address == {1'b0, rsp_payload.write_address} + 13'd1)
      else $error("end address does not follow the written byte");

   // Writes only come with a running or a too-many-tokens status.
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_valid |->
         (rsp_payload.status == ST_RUN) || (rsp_payload.status == ST_FMT))
      else $error("write reported with an unexpected status");

   // The load never ends below where it started.
   a_addr_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.end_address >= {1'b0, rsp_payload.start_address})
      else $error("end address below start address");

   // Nothing is offered in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind ascii_hex_memory_loader ahml_checker u_ahml_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
